>>> rtl/core/m3i_pkg.sv
// shared constants for the 3x3 matrix inverse pipeline
package m3i_pkg;

  // matrix geometry
  localparam int NUM_ELEM = 9;
  localparam int ROW_LEN  = 3;

  // threshold register
  localparam int              THR_BITS  = 31;
  localparam logic [30:0]     THR_RESET = 31'd1;

  // cofactor k = m[p]*m[q] - m[r]*m[s], elements numbered row by row
  localparam int ADJ_IDX [NUM_ELEM][4] = '{
    '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // cofactors that pair with the first row in the determinant
  localparam int DET_IDX [ROW_LEN] = '{0, 3, 6};

endpackage

>>> rtl/core/matrix3_inverse_unit.sv
// 3x3 matrix inverse by the adjugate: top level with handshake and threshold register
//
// Input channel: in_valid_i with the nine elements a00_i..a22_i (signed fixed
// point, row by row); an item is taken when in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o with b00_o..b22_o (inverse, row by row),
// determinant_o and singular_o; an item leaves when out_stall_i is low.
// Configuration: cfg_singular_threshold_i is written when cfg_valid_i is high;
// cfg_ready_o is always high. Write it only while no item is in flight.
// The divider resolves one quotient bit per stage for all nine elements at once.
// Throughput is one matrix per cycle while the output is not stalled. A stalled
// output holding a finished item freezes the whole pipeline; in_stall_o follows
// at once and nothing is lost or repeated. Reset empties the pipeline and sets the
// threshold to one least significant bit. Singular matrices give a zero
// inverse with the determinant still reported; overflowing results saturate.
module matrix3_inverse_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [WORD_BITS-1:0]   a00_i,
  input  logic signed [WORD_BITS-1:0]   a01_i,
  input  logic signed [WORD_BITS-1:0]   a02_i,
  input  logic signed [WORD_BITS-1:0]   a10_i,
  input  logic signed [WORD_BITS-1:0]   a11_i,
  input  logic signed [WORD_BITS-1:0]   a12_i,
  input  logic signed [WORD_BITS-1:0]   a20_i,
  input  logic signed [WORD_BITS-1:0]   a21_i,
  input  logic signed [WORD_BITS-1:0]   a22_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [WORD_BITS-1:0]   b00_o,
  output logic signed [WORD_BITS-1:0]   b01_o,
  output logic signed [WORD_BITS-1:0]   b02_o,
  output logic signed [WORD_BITS-1:0]   b10_o,
  output logic signed [WORD_BITS-1:0]   b11_o,
  output logic signed [WORD_BITS-1:0]   b12_o,
  output logic signed [WORD_BITS-1:0]   b20_o,
  output logic signed [WORD_BITS-1:0]   b21_o,
  output logic signed [WORD_BITS-1:0]   b22_o,
  output logic signed [WORD_BITS-1:0]   determinant_o,
  output logic                          singular_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [m3i_pkg::THR_BITS-1:0]  cfg_singular_threshold_i
);
  import m3i_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int LAT = W + 9;

  logic                 en;
  logic [LAT-1:0]       vld_q;
  logic [THR_BITS-1:0]  thr_q;

  logic signed [W-1:0]  a      [NUM_ELEM];
  logic signed [2*W:0]  adj    [NUM_ELEM];
  logic signed [W-1:0]  row    [ROW_LEN];
  logic [3*W+1:0]       absd;
  logic                 dneg;
  logic [2*W:0]         absadj [NUM_ELEM];
  logic                 qneg   [NUM_ELEM];
  logic signed [W-1:0]  res    [NUM_ELEM];

  // pipeline advances unless a finished item is held at the output
  assign en          = !vld_q[LAT-1] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];
  assign cfg_ready_o = 1'b1;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_singular_threshold_i;
    end
  end

  assign a[0] = a00_i;
  assign a[1] = a01_i;
  assign a[2] = a02_i;
  assign a[3] = a10_i;
  assign a[4] = a11_i;
  assign a[5] = a12_i;
  assign a[6] = a20_i;
  assign a[7] = a21_i;
  assign a[8] = a22_i;

  m3i_cofactor #(
    .WORD_BITS (WORD_BITS)
  ) u_cofactor (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (a),
    .adj_o (adj),
    .row_o (row)
  );

  m3i_det #(
    .WORD_BITS (WORD_BITS)
  ) u_det (
    .clk_i    (clk_i),
    .en_i     (en),
    .adj_i    (adj),
    .row_i    (row),
    .absd_o   (absd),
    .dneg_o   (dneg),
    .absadj_o (absadj),
    .qneg_o   (qneg)
  );

  m3i_quot #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_quot (
    .clk_i    (clk_i),
    .en_i     (en),
    .thr_i    (thr_q),
    .absd_i   (absd),
    .dneg_i   (dneg),
    .absadj_i (absadj),
    .qneg_i   (qneg),
    .res_o    (res),
    .det_o    (determinant_o),
    .sing_o   (singular_o)
  );

  assign b00_o = res[0];
  assign b01_o = res[1];
  assign b02_o = res[2];
  assign b10_o = res[3];
  assign b11_o = res[4];
  assign b12_o = res[5];
  assign b20_o = res[6];
  assign b21_o = res[7];
  assign b22_o = res[8];

endmodule

>>> rtl/core/m3i_cofactor.sv
// cofactor stages: 2x2 products, then the adjugate differences
module m3i_cofactor #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [WORD_BITS-1:0] a_i   [m3i_pkg::NUM_ELEM],
  output logic signed [2*WORD_BITS:0] adj_o [m3i_pkg::NUM_ELEM],
  output logic signed [WORD_BITS-1:0] row_o [m3i_pkg::ROW_LEN]
);
  import m3i_pkg::*;

  localparam int W = WORD_BITS;

  logic signed [2*W-1:0] pa_q   [NUM_ELEM];
  logic signed [2*W-1:0] pb_q   [NUM_ELEM];
  logic signed [2*W:0]   adj_q  [NUM_ELEM];
  logic signed [W-1:0]   row0_q [ROW_LEN];
  logic signed [W-1:0]   row1_q [ROW_LEN];

  // product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        pa_q[k] <= a_i[ADJ_IDX[k][0]] * a_i[ADJ_IDX[k][1]];
        pb_q[k] <= a_i[ADJ_IDX[k][2]] * a_i[ADJ_IDX[k][3]];
      end
      for (int j = 0; j < ROW_LEN; j++) begin
        row0_q[j] <= a_i[j];
      end
    end
  end

  // difference stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        adj_q[k] <= {pa_q[k][2*W-1], pa_q[k]} - {pb_q[k][2*W-1], pb_q[k]};
      end
      for (int j = 0; j < ROW_LEN; j++) begin
        row1_q[j] <= row0_q[j];
      end
    end
  end

  assign adj_o = adj_q;
  assign row_o = row1_q;

endmodule

>>> rtl/core/m3i_det.sv
// determinant stages: split products, term sums, total, magnitudes and signs
module m3i_det #(
  parameter int WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [2*WORD_BITS:0]   adj_i    [m3i_pkg::NUM_ELEM],
  input  logic signed [WORD_BITS-1:0]   row_i    [m3i_pkg::ROW_LEN],
  output logic        [3*WORD_BITS+1:0] absd_o,
  output logic                          dneg_o,
  output logic        [2*WORD_BITS:0]   absadj_o [m3i_pkg::NUM_ELEM],
  output logic                          qneg_o   [m3i_pkg::NUM_ELEM]
);
  import m3i_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int AW = 2 * W + 1;
  localparam int DW = 3 * W + 2;

  logic signed [AW-1:0] lo_q   [ROW_LEN];
  logic signed [AW-1:0] hi_q   [ROW_LEN];
  logic signed [DW-1:0] term_q [ROW_LEN];
  logic signed [DW-1:0] det_q;
  logic signed [AW-1:0] adjc_q [NUM_ELEM];
  logic signed [AW-1:0] adjd_q [NUM_ELEM];
  logic signed [AW-1:0] adje_q [NUM_ELEM];
  logic        [DW-1:0] absd_q;
  logic                 dneg_q;
  logic        [AW-1:0] absadj_q [NUM_ELEM];
  logic                 qneg_q   [NUM_ELEM];

  // partial products of row element by low and high cofactor halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < ROW_LEN; j++) begin
        lo_q[j] <= row_i[j] * $signed({1'b0, adj_i[DET_IDX[j]][W-1:0]});
        hi_q[j] <= row_i[j] * $signed(adj_i[DET_IDX[j]][AW-1:W]);
      end
      adjc_q <= adj_i;
    end
  end

  // recombine halves into one term per row element
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < ROW_LEN; j++) begin
        term_q[j] <= DW'(lo_q[j]) + (DW'(hi_q[j]) <<< W);
      end
      adjd_q <= adjc_q;
    end
  end

  // determinant sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q  <= term_q[0] + term_q[1] + term_q[2];
      adje_q <= adjd_q;
    end
  end

  // magnitudes and quotient signs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      absd_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      dneg_q <= det_q[DW-1];
      for (int k = 0; k < NUM_ELEM; k++) begin
        absadj_q[k] <= adje_q[k][AW-1] ? AW'(-adje_q[k]) : AW'(adje_q[k]);
        qneg_q[k]   <= adje_q[k][AW-1] ^ det_q[DW-1];
      end
    end
  end

  assign absd_o   = absd_q;
  assign dneg_o   = dneg_q;
  assign absadj_o = absadj_q;
  assign qneg_o   = qneg_q;

endmodule

>>> rtl/core/m3i_quot.sv
// pipelined restoring dividers for the nine inverse elements, plus output rounding
module m3i_quot #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [m3i_pkg::THR_BITS-1:0]  thr_i,
  input  logic [3*WORD_BITS+1:0]        absd_i,
  input  logic                          dneg_i,
  input  logic [2*WORD_BITS:0]          absadj_i [m3i_pkg::NUM_ELEM],
  input  logic                          qneg_i   [m3i_pkg::NUM_ELEM],
  output logic signed [WORD_BITS-1:0]   res_o    [m3i_pkg::NUM_ELEM],
  output logic signed [WORD_BITS-1:0]   det_o,
  output logic                          sing_o
);
  import m3i_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int AW  = 2 * W + 1;
  localparam int DW  = 3 * W + 2;
  localparam int NW  = AW + 2 * F + 1;
  localparam int RW  = (NW > DW + W + 1) ? NW : DW + W + 1;
  localparam int TW  = (DW > THR_BITS + 2 * F) ? DW : THR_BITS + 2 * F;
  localparam int MB  = (DW - 2 * F > W + 1) ? DW - 2 * F : W + 1;
  localparam int MW  = MB + 1;
  localparam int STG = W + 2;

  localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0]    LIMQ = (W+1)'(1) << (W - 1);
  localparam logic [MW-1:0] LIMD = MW'(1) << (W - 1);

  logic [RW-1:0] rem_q  [STG-1][NUM_ELEM];
  logic [DW-1:0] dv_q   [STG-1];
  logic [W:0]    quo_q  [STG][NUM_ELEM];
  logic          sat_q  [STG][NUM_ELEM];
  logic          neg_q  [STG][NUM_ELEM];
  logic          sing_q [STG];
  logic [MW-1:0] dmag_q [STG];
  logic          dneg_q [STG];

  logic [W+1:0]  rsum  [NUM_ELEM];
  logic [W:0]    rnd   [NUM_ELEM];
  logic [W-1:0]  res_d [NUM_ELEM];
  logic [W-1:0]  det_d;
  logic [W-1:0]  res_q [NUM_ELEM];
  logic [W-1:0]  det_q;
  logic          sing_out_q;

  // entry: overflow check, singular test, determinant rounding
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        rem_q[0][k] <= RW'(absadj_i[k]) << (2 * F + 1);
        sat_q[0][k] <= (RW'(absadj_i[k]) << (2 * F + 1)) >= (RW'(absd_i) << (W + 1));
        quo_q[0][k] <= '0;
        neg_q[0][k] <= qneg_i[k];
      end
      dv_q[0]   <= absd_i;
      sing_q[0] <= (absd_i == '0) || (TW'(absd_i) < (TW'(thr_i) << (2 * F)));
      dmag_q[0] <= MW'(absd_i >> (2 * F)) + MW'(absd_i[2*F-1]);
      dneg_q[0] <= dneg_i;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 1; s < STG; s++) begin : g_step
    localparam int B = STG - 1 - s;
    logic ge [NUM_ELEM];

    always_comb begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        ge[k] = rem_q[s-1][k] >= (RW'(dv_q[s-1]) << B);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < NUM_ELEM; k++) begin
          quo_q[s][k] <= ge[k] ? (quo_q[s-1][k] | ((W+1)'(1) << B)) : quo_q[s-1][k];
          sat_q[s][k] <= sat_q[s-1][k];
          neg_q[s][k] <= neg_q[s-1][k];
        end
        sing_q[s] <= sing_q[s-1];
        dmag_q[s] <= dmag_q[s-1];
        dneg_q[s] <= dneg_q[s-1];
      end
    end

    if (s < STG - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          for (int k = 0; k < NUM_ELEM; k++) begin
            rem_q[s][k] <= ge[k] ? (rem_q[s-1][k] - (RW'(dv_q[s-1]) << B))
                                 : rem_q[s-1][k];
          end
          dv_q[s] <= dv_q[s-1];
        end
      end
    end
  end

  // round half away from zero, apply sign, saturate, zero when singular
  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      rsum[k] = {1'b0, quo_q[STG-1][k]} + (W+2)'(1);
      rnd[k]  = rsum[k][W+1:1];
      if (sing_q[STG-1]) begin
        res_d[k] = '0;
      end else if (sat_q[STG-1][k]) begin
        res_d[k] = neg_q[STG-1][k] ? MINV : MAXV;
      end else if (neg_q[STG-1][k]) begin
        res_d[k] = (rnd[k] > LIMQ) ? MINV : W'(~rnd[k] + (W+1)'(1));
      end else begin
        res_d[k] = (rnd[k] > LIMQ - (W+1)'(1)) ? MAXV : W'(rnd[k]);
      end
    end
    if (dneg_q[STG-1]) begin
      det_d = (dmag_q[STG-1] > LIMD) ? MINV : W'(~dmag_q[STG-1] + MW'(1));
    end else begin
      det_d = (dmag_q[STG-1] > LIMD - MW'(1)) ? MAXV : W'(dmag_q[STG-1]);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q      <= res_d;
      det_q      <= det_d;
      sing_out_q <= sing_q[STG-1];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      res_o[k] = $signed(res_q[k]);
    end
  end
  assign det_o  = $signed(det_q);
  assign sing_o = sing_out_q;

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the 3x3 matrix inverse unit
module tb;
  import m3i_pkg::*;

  localparam int W = 32;
  localparam int F = 16;
  localparam int LATENCY = W + 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [W-1:0] ONE = 32'sd65536;
  localparam logic signed [W-1:0] WMAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] WMIN = 32'sh80000000;

  typedef logic signed [159:0] wide_t;
  typedef logic signed [W-1:0] word_t;

  typedef struct {
    word_t b [NUM_ELEM];
    word_t det;
    logic  sing;
  } inverse_t;

  // expected inverses, oldest first, with the predictor's copy of the threshold
  class inverse_board;
    inverse_t pending [$];
    logic [THR_BITS-1:0] thr;
    int errors;

    function new();
      thr = THR_RESET;
      errors = 0;
    endfunction

    // signed quotient rounded to nearest, ties away from zero
    function wide_t div_near(wide_t n, wide_t d);
      wide_t an, ad, q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = (2 * an + ad) / (2 * ad);
      return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function word_t clamp(wide_t v);
      if (v > wide_t'(WMAX)) return WMAX;
      if (v < wide_t'(WMIN)) return WMIN;
      return word_t'(v);
    endfunction

    // predict the inverse of an accepted matrix
    function void note_matrix(word_t m [NUM_ELEM]);
      wide_t x [NUM_ELEM];
      wide_t cof [NUM_ELEM];
      wide_t d, ad, lim;
      inverse_t r;
      for (int k = 0; k < NUM_ELEM; k++) x[k] = m[k];
      for (int k = 0; k < NUM_ELEM; k++)
        cof[k] = x[ADJ_IDX[k][0]] * x[ADJ_IDX[k][1]] - x[ADJ_IDX[k][2]] * x[ADJ_IDX[k][3]];
      d = x[0] * cof[0] + x[1] * cof[3] + x[2] * cof[6];
      r.det = clamp(div_near(d, wide_t'(1) <<< (2 * F)));
      ad = d < 0 ? -d : d;
      lim = wide_t'({1'b0, thr}) <<< (2 * F);
      r.sing = (d == 0) || (ad < lim);
      for (int k = 0; k < NUM_ELEM; k++)
        r.b[k] = r.sing ? '0 : clamp(div_near(cof[k] <<< (2 * F), d));
      pending.push_back(r);
    endfunction

    // compare one delivered inverse with the oldest prediction
    function void check_inverse(inverse_t got);
      string names [NUM_ELEM] = '{"b00", "b01", "b02", "b10", "b11", "b12",
                                  "b20", "b21", "b22"};
      inverse_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < NUM_ELEM; k++)
        if (got.b[k] !== e.b[k]) begin
          $error("%s: expected %0d, actual %0d", names[k], e.b[k], got.b[k]);
          errors++;
        end
      if (got.det !== e.det) begin
        $error("determinant: expected %0d, actual %0d", e.det, got.det);
        errors++;
      end
      if (got.sing !== e.sing) begin
        $error("singular: expected %0d, actual %0d", e.sing, got.sing);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  word_t a_i [NUM_ELEM] = '{default: '0};
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  word_t b_o [NUM_ELEM];
  word_t determinant_o;
  logic singular_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [THR_BITS-1:0] cfg_singular_threshold_i = '0;

  inverse_board board = new();
  int cycles = 0;
  int sent = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  matrix3_inverse_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .a00_i(a_i[0]), .a01_i(a_i[1]), .a02_i(a_i[2]),
    .a10_i(a_i[3]), .a11_i(a_i[4]), .a12_i(a_i[5]),
    .a20_i(a_i[6]), .a21_i(a_i[7]), .a22_i(a_i[8]),
    .out_valid_o, .out_stall_i,
    .b00_o(b_o[0]), .b01_o(b_o[1]), .b02_o(b_o[2]),
    .b10_o(b_o[3]), .b11_o(b_o[4]), .b12_o(b_o[5]),
    .b20_o(b_o[6]), .b21_o(b_o[7]), .b22_o(b_o[8]),
    .determinant_o, .singular_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_singular_threshold_i
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // monitors on both channels
  always @(posedge clk_i) begin
    inverse_t got;
    if (rst_ni && in_valid_i && !in_stall_o) board.note_matrix(a_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.b = b_o;
      got.det = determinant_o;
      got.sing = singular_o;
      board.check_inverse(got);
    end
  end

  // receiver: random stalls, one long hold-off, quiet stretch
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold == 0) begin
        hold = 300;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = !quiet && ($urandom_range(0, 99) < 6);
      end
    end
  end

  // offer one matrix and wait until it is taken
  task automatic send_matrix(word_t m [NUM_ELEM]);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    a_i = m;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // threshold write while the pipeline is empty
  task automatic write_threshold(logic [THR_BITS-1:0] v);
    end_burst();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_singular_threshold_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.thr = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic word_t rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return WMAX - word_t'($urandom_range(0, 3));
      2: return WMIN + word_t'($urandom_range(0, 3));
      3: return word_t'($urandom_range(0, 65535)) - 32'sd32768;
      default: return word_t'($urandom_range(0, 524288)) - 32'sd262144;
    endcase
  endfunction

  // random matrix: mostly well conditioned, the rest raw, tiny or rank deficient
  task automatic send_random();
    word_t m [NUM_ELEM];
    int shape;
    shape = $urandom_range(0, 9);
    for (int k = 0; k < NUM_ELEM; k++) m[k] = rand_elem();
    if (shape < 6) begin
      for (int k = 0; k < NUM_ELEM; k++)
        m[k] = word_t'($urandom_range(0, 131072)) - 32'sd65536;
      for (int k = 0; k < NUM_ELEM; k += 4)
        m[k] = word_t'($urandom_range(65536, 1048576)) * ($urandom_range(0, 1) ? 1 : -1);
    end else if (shape == 6) begin
      // third row repeats the first, so the matrix is singular
      for (int k = 0; k < ROW_LEN; k++) m[6 + k] = m[k];
    end else if (shape == 7) begin
      // tiny elements give a determinant near the threshold
      for (int k = 0; k < NUM_ELEM; k++) m[k] = word_t'($urandom_range(0, 512)) - 32'sd256;
    end
    send_matrix(m);
  endtask

  initial begin
    word_t m [NUM_ELEM];
    logic [THR_BITS-1:0] thr_set [4] = '{31'd0, 31'h7fffffff, 31'd65536, 31'd1};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero, identity, extremes, scaling, singular and overflow cases
    m = '{default: '0};                                      send_matrix(m);
    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};                  send_matrix(m);
    m = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};                 send_matrix(m);
    m = '{ONE * 2, 0, 0, 0, ONE / 2, 0, 0, 0, ONE * 4};      send_matrix(m);
    m = '{32'sd1, 0, 0, 0, 32'sd1, 0, 0, 0, 32'sd1};         send_matrix(m);
    m = '{32'sd256, 0, 0, 0, 32'sd256, 0, 0, 0, 32'sd256};   send_matrix(m);
    m = '{default: WMAX};                                    send_matrix(m);
    m = '{default: WMIN};                                    send_matrix(m);
    m = '{WMAX, 0, 0, 0, WMAX, 0, 0, 0, WMAX};               send_matrix(m);
    m = '{WMIN, 0, 0, 0, WMIN, 0, 0, 0, WMIN};               send_matrix(m);
    m = '{WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMAX}; send_matrix(m);
    m = '{32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6, 32'sd7, 32'sd8, 32'sd10};
    send_matrix(m);
    m = '{ONE, ONE * 2, ONE * 3, ONE * 4, ONE * 5, ONE * 6, ONE * 7, ONE * 8, ONE * 9};
    send_matrix(m);
    m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};                  send_matrix(m);
    m = '{ONE * 3, ONE, 0, ONE, ONE * 2, ONE, 0, ONE, ONE * 3}; send_matrix(m);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};               send_matrix(m);
    m = '{32'sd65535, 0, 0, 0, ONE, 0, 0, 0, ONE};           send_matrix(m);

    // threshold phases, extremes included, with random matrices in each
    foreach (thr_set[p]) begin
      write_threshold(thr_set[p]);
      repeat (40) send_random();
    end
    write_threshold(31'($urandom));
    repeat (40) send_random();
    write_threshold(31'($urandom_range(1, 1 << 20)));

    // main random run: a quiet stretch and one long receiver hold-off
    for (int i = 0; i < 230; i++) begin
      quiet = (i >= 60 && i < 140);
      if (i == 160) hold_req = 1'b1;
      send_random();
    end
    quiet = 1'b0;
    end_burst();

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
